// File: rtl/bdr_pkg.sv
// Package for the bus decoded byte RAM: field widths, status and register codes,
// and the control struct passed from the decoder to the datapath. No dependencies.
`timescale 1ns / 1ps

package bdr_pkg;

   localparam int BDR_RAM_BYTES = 65536;

   localparam int BDR_ADDR_W  = 64;
   localparam int BDR_DATA_W  = 64;
   localparam int BDR_WIDTH_W = 4;
   localparam int BDR_KIND_W  = 3;
   localparam int BDR_STAT_W  = 2;
   localparam int BDR_SIZE_W  = 17;
   localparam int BDR_LANES   = 8;
   localparam int BDR_LANE_W  = 3;

   localparam int BDR_CSR_IDX_W = 2;
   localparam logic [BDR_CSR_IDX_W-1:0] BDR_CSR_RAM_BASE = 2'd0;
   localparam logic [BDR_CSR_IDX_W-1:0] BDR_CSR_RAM_SIZE = 2'd1;

   localparam logic [BDR_SIZE_W-1:0] BDR_RAM_SIZE_RESET = 17'h10000;

   localparam logic BDR_OP_READ  = 1'b0;
   localparam logic BDR_OP_WRITE = 1'b1;

   typedef enum logic [BDR_STAT_W-1:0] {
      BDR_ST_OK        = 2'd0,
      BDR_ST_BAD_WIDTH = 2'd1,
      BDR_ST_UNMAPPED  = 2'd2
   } bdr_status_type;

   typedef struct packed {
      bdr_status_type          status;
      logic [BDR_LANE_W-1:0]   lane_lo;
   } bdr_ctl_type;

endpackage

// File: rtl/bdr_req_if.sv
// Request channel of the bus decoded byte RAM: valid/ready plus one bus access.
// Depends on bdr_pkg.
`timescale 1ns / 1ps

interface bdr_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic [bdr_pkg::BDR_ADDR_W-1:0]     bus_address;
   logic [bdr_pkg::BDR_WIDTH_W-1:0]    access_width;
   logic [bdr_pkg::BDR_DATA_W-1:0]     write_data;
   logic [bdr_pkg::BDR_KIND_W-1:0]     access_kind;

   modport source (output valid, opcode, bus_address, access_width, write_data, access_kind,
                   input ready);
   modport sink (input valid, opcode, bus_address, access_width, write_data, access_kind,
                 output ready);
endinterface

// File: rtl/bdr_rsp_if.sv
// Response channel of the bus decoded byte RAM: valid/ready plus one access result.
// Depends on bdr_pkg.
`timescale 1ns / 1ps

interface bdr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bdr_pkg::BDR_DATA_W-1:0]     read_data;
   logic [bdr_pkg::BDR_STAT_W-1:0]     status;
   logic [bdr_pkg::BDR_ADDR_W-1:0]     fault_address;
   logic [bdr_pkg::BDR_WIDTH_W-1:0]    fault_width;
   logic [bdr_pkg::BDR_KIND_W-1:0]     fault_kind;

   modport source (output valid, read_data, status, fault_address, fault_width, fault_kind,
                   input ready);
   modport sink (input valid, read_data, status, fault_address, fault_width, fault_kind,
                 output ready);
endinterface

// File: rtl/bdr_ram.sv
// Generic single port RAM with registered read data; read data holds when not enabled.
// No dependencies.
`timescale 1ns / 1ps

module bdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bdr_decode.sv
// Access decoder: width check, window containment, and per-bank row, write enable
// and write byte for the eight byte banks. Depends on bdr_pkg.
`timescale 1ns / 1ps

module bdr_decode #(
   parameter int RAM_BYTES = bdr_pkg::BDR_RAM_BYTES,
   parameter int ROW_W     = 13,
   parameter int SIZE_W    = 17
) (
   input  logic                              opcode,
   input  logic [bdr_pkg::BDR_WIDTH_W-1:0]   access_width,
   input  logic [bdr_pkg::BDR_DATA_W-1:0]    write_data,
   input  logic [bdr_pkg::BDR_ADDR_W:0]      diff,
   input  logic [bdr_pkg::BDR_SIZE_W-1:0]    ram_size,
   output bdr_pkg::bdr_ctl_type              ctl,
   output logic [bdr_pkg::BDR_LANES-1:0]     bank_we,
   output logic [ROW_W-1:0]                  bank_row   [bdr_pkg::BDR_LANES],
   output logic [7:0]                        bank_wdata [bdr_pkg::BDR_LANES]
);
   import bdr_pkg::*;

   logic [SIZE_W-1:0]   win_size;
   logic [SIZE_W-1:0]   off;
   logic [SIZE_W:0]     off_end;
   logic                width_ok;
   logic                mapped;
   logic [ROW_W-1:0]    row0;
   logic [BDR_LANE_W-1:0] lo;

   always_comb begin
      if (64'(ram_size) > 64'(RAM_BYTES)) begin
         win_size = SIZE_W'(RAM_BYTES);
      end else begin
         win_size = SIZE_W'(ram_size);
      end
   end

   assign off      = diff[SIZE_W-1:0];
   assign off_end  = {1'b0, off} + (SIZE_W+1)'(access_width);
   assign width_ok = access_width inside {4'd1, 4'd2, 4'd4, 4'd8};
   assign mapped   = !diff[BDR_ADDR_W] && (diff[BDR_ADDR_W-1:SIZE_W] == '0)
                     && (off_end <= {1'b0, win_size});
   assign lo       = off[BDR_LANE_W-1:0];
   assign row0     = ROW_W'(off >> BDR_LANE_W);

   always_comb begin
      ctl.lane_lo = lo;
      if (!width_ok) begin
         ctl.status = BDR_ST_BAD_WIDTH;
      end else if (!mapped) begin
         ctl.status = BDR_ST_UNMAPPED;
      end else begin
         ctl.status = BDR_ST_OK;
      end
   end

   for (genvar b = 0; b < BDR_LANES; b++) begin : g_bank
      logic [BDR_LANE_W-1:0] lane;
      assign lane = BDR_LANE_W'(b) - lo;
      assign bank_row[b]   = row0 + ROW_W'(BDR_LANE_W'(b) < lo);
      assign bank_wdata[b] = write_data[lane*8 +: 8];
      assign bank_we[b]    = (opcode == BDR_OP_WRITE) && (ctl.status == BDR_ST_OK)
                             && ({1'b0, lane} < access_width);
   end

endmodule

// File: rtl/bus_decoded_byte_ram_unit.sv
// Bus decoded byte RAM, top level. Depends on bdr_pkg, bdr_req_if, bdr_rsp_if,
// bdr_decode and bdr_ram.
`timescale 1ns / 1ps

// Usage
//   req_chan takes one bus access per request: opcode (read or write), a byte
//   address, a width of 1, 2, 4 or 8 bytes, write data and an access kind.
//   rsp_chan returns one result per request: little-endian read data, a status
//   (ok, bad width, unmapped) and, on a fault, the echoed address, width, kind.
//   The csr_ port writes ram_base (index 0) and ram_size (index 1); write them only while idle (not enforced).
// Timing
//   The store is eight byte-wide banks of RAM_BYTES/8 rows; any width, aligned
//   or not, is one access: a read reads all eight banks, a write only the banks
//   it covers. A request is registered, decoded and sent to the banks, then the
//   read data is assembled into the output register. Only an empty request register
//   takes a request, and only while the s2 register or the output register is empty.
// Reset
//   After reset the banks are zeroed one row per cycle, from row 0 to the last
//   row, while req_chan.ready stays low.
// Stall
//   A result waits in the output register while rsp_chan.ready is low; one more
//   request may be taken and held until the output register frees up.
module bus_decoded_byte_ram_unit #(
   parameter int RAM_BYTES = bdr_pkg::BDR_RAM_BYTES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bdr_req_if.sink                              req_chan,
   bdr_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [bdr_pkg::BDR_CSR_IDX_W-1:0]    csr_index,
   input  logic [bdr_pkg::BDR_ADDR_W-1:0]       csr_write_data
);
   import bdr_pkg::*;

   localparam int BANK_DEPTH = (RAM_BYTES + BDR_LANES - 1) / BDR_LANES;
   localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int SIZE_W     = $clog2(RAM_BYTES + 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BANK_DEPTH - 1);

   logic [BDR_ADDR_W-1:0] ram_base_ff;
   logic [BDR_SIZE_W-1:0] ram_size_ff;

   logic                  clr_busy_ff;
   logic [ROW_W-1:0]      clr_row_ff, clr_row_in;

   logic                  s1_vld_ff, s1_vld_in;
   logic                  s1_op_ff;
   logic [BDR_ADDR_W-1:0] s1_addr_ff;
   logic [BDR_WIDTH_W-1:0] s1_width_ff;
   logic [BDR_DATA_W-1:0] s1_data_ff;
   logic [BDR_KIND_W-1:0] s1_kind_ff;
   logic [BDR_ADDR_W:0]   s1_diff_ff;

   logic                  s2_vld_ff, s2_vld_in;
   logic                  s2_op_ff;
   bdr_ctl_type           s2_ctl_ff;
   logic [BDR_ADDR_W-1:0] s2_addr_ff;
   logic [BDR_WIDTH_W-1:0] s2_width_ff;
   logic [BDR_KIND_W-1:0] s2_kind_ff;

   logic                  out_vld_ff, out_vld_in;
   logic [BDR_DATA_W-1:0] out_rdata_ff;
   logic [BDR_STAT_W-1:0] out_status_ff;
   logic [BDR_ADDR_W-1:0] out_faddr_ff;
   logic [BDR_WIDTH_W-1:0] out_fwidth_ff;
   logic [BDR_KIND_W-1:0] out_fkind_ff;

   logic                  req_take;
   logic                  s1_move;
   logic                  s2_move;

   bdr_ctl_type           dec_ctl;
   logic [BDR_LANES-1:0]  dec_we;
   logic [ROW_W-1:0]      dec_row   [BDR_LANES];
   logic [7:0]            dec_wdata [BDR_LANES];
   logic [7:0]            bank_q    [BDR_LANES];

   logic [BDR_DATA_W-1:0] asm_data;
   logic                  s2_fault;

   // handshake
   assign req_chan.ready = !clr_busy_ff && !s1_vld_ff && (!s2_vld_ff || !out_vld_ff);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign s2_move        = s2_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign s1_move        = s1_vld_ff && (!s2_vld_ff || s2_move);

   assign s1_vld_in  = req_take || (s1_vld_ff && !s1_move);
   assign s2_vld_in  = s1_move || (s2_vld_ff && !s2_move);
   assign out_vld_in = s2_move || (out_vld_ff && !rsp_chan.ready);
   assign clr_row_in = clr_row_ff + ROW_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_base_ff <= '0;
         ram_size_ff <= BDR_RAM_SIZE_RESET;
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               BDR_CSR_RAM_BASE: ram_base_ff <= csr_write_data;
               BDR_CSR_RAM_SIZE: ram_size_ff <= csr_write_data[BDR_SIZE_W-1:0];
               default: ;
            endcase
         end
         if (clr_busy_ff) begin
            clr_row_ff <= clr_row_in;
            if (clr_row_ff == LAST_ROW) begin
               clr_busy_ff <= 1'b0;
            end
         end
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // request register; offset from the window base is formed here
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_chan.opcode;
         s1_addr_ff  <= req_chan.bus_address;
         s1_width_ff <= req_chan.access_width;
         s1_data_ff  <= req_chan.write_data;
         s1_kind_ff  <= req_chan.access_kind;
         s1_diff_ff  <= {1'b0, req_chan.bus_address} - {1'b0, ram_base_ff};
      end
   end

   bdr_decode #(
      .RAM_BYTES (RAM_BYTES),
      .ROW_W     (ROW_W),
      .SIZE_W    (SIZE_W)
   ) u_decode (
      .opcode       (s1_op_ff),
      .access_width (s1_width_ff),
      .write_data   (s1_data_ff),
      .diff         (s1_diff_ff),
      .ram_size     (ram_size_ff),
      .ctl          (dec_ctl),
      .bank_we      (dec_we),
      .bank_row     (dec_row),
      .bank_wdata   (dec_wdata)
   );

   for (genvar b = 0; b < BDR_LANES; b++) begin : g_bank
      logic             en;
      logic             we;
      logic [ROW_W-1:0] addr;
      logic [7:0]       wdata;

      always_comb begin
         if (clr_busy_ff) begin
            en    = 1'b1;
            we    = 1'b1;
            addr  = clr_row_ff;
            wdata = '0;
         end else begin
            en    = s1_move;
            we    = dec_we[b] || (s1_op_ff == BDR_OP_WRITE);
            addr  = dec_row[b];
            wdata = dec_wdata[b];
            if (s1_op_ff == BDR_OP_WRITE) begin
               en = s1_move && dec_we[b];
            end
         end
      end

      bdr_ram #(
         .WIDTH (8),
         .DEPTH (BANK_DEPTH),
         .AW    (ROW_W)
      ) u_bank (
         .clock (clock),
         .en    (en),
         .we    (we),
         .addr  (addr),
         .wdata (wdata),
         .rdata (bank_q[b])
      );
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_op_ff    <= s1_op_ff;
         s2_ctl_ff   <= dec_ctl;
         s2_addr_ff  <= s1_addr_ff;
         s2_width_ff <= s1_width_ff;
         s2_kind_ff  <= s1_kind_ff;
      end
   end

   // byte i of the result comes from bank (lane_lo + i) mod 8
   always_comb begin
      logic [BDR_LANE_W-1:0] bank_sel;
      asm_data = '0;
      for (int i = 0; i < BDR_LANES; i++) begin
         bank_sel = s2_ctl_ff.lane_lo + BDR_LANE_W'(i);
         if (BDR_WIDTH_W'(i) < s2_width_ff) begin
            asm_data[i*8 +: 8] = bank_q[bank_sel];
         end
      end
   end

   assign s2_fault = (s2_ctl_ff.status != BDR_ST_OK);

   always_ff @(posedge clock) begin
      if (s2_move) begin
         out_status_ff <= s2_ctl_ff.status;
         out_rdata_ff  <= (!s2_fault && (s2_op_ff == BDR_OP_READ)) ? asm_data : '0;
         out_faddr_ff  <= s2_fault ? s2_addr_ff  : '0;
         out_fwidth_ff <= s2_fault ? s2_width_ff : '0;
         out_fkind_ff  <= s2_fault ? s2_kind_ff  : '0;
      end
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.read_data     = out_rdata_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.fault_address = out_faddr_ff;
   assign rsp_chan.fault_width   = out_fwidth_ff;
   assign rsp_chan.fault_kind    = out_fkind_ff;

endmodule

// File: bench/bus_decoded_byte_ram_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for bus_decoded_byte_ram_unit: directed and random bus accesses over several
// RAM window settings, checked against a byte-array model of the window and store.
// Depends on bdr_pkg, bdr_req_if, bdr_rsp_if and bus_decoded_byte_ram_unit.

module bus_decoded_byte_ram_unit_tb;
   import bdr_pkg::*;

   localparam logic [BDR_CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [BDR_CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam logic [BDR_KIND_W-1:0] KIND_FETCH = 3'd0;
   localparam logic [BDR_KIND_W-1:0] KIND_LOAD  = 3'd1;
   localparam logic [BDR_KIND_W-1:0] KIND_STORE = 3'd2;
   localparam logic [BDR_KIND_W-1:0] KIND_WALK  = 3'd3;
   localparam logic [BDR_KIND_W-1:0] KIND_IMAGE = 3'd4;
   localparam logic [BDR_KIND_W-1:0] KIND_RSVD5 = 3'd5;
   localparam logic [BDR_KIND_W-1:0] KIND_RSVD7 = 3'd7;

   localparam logic [BDR_ADDR_W-1:0] ADDR_TOP = '1;

   typedef struct {
      logic                   opcode;
      logic [BDR_ADDR_W-1:0]  address;
      logic [BDR_WIDTH_W-1:0] width;
      logic [BDR_DATA_W-1:0]  wdata;
      logic [BDR_KIND_W-1:0]  kind;
   } bus_access_type;

   typedef struct {
      logic [BDR_DATA_W-1:0]  read_data;
      bdr_status_type         status;
      logic [BDR_ADDR_W-1:0]  fault_address;
      logic [BDR_WIDTH_W-1:0] fault_width;
      logic [BDR_KIND_W-1:0]  fault_kind;
   } access_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable;
   logic [BDR_CSR_IDX_W-1:0] csr_index;
   logic [BDR_ADDR_W-1:0]    csr_write_data;

   bdr_req_if req_chan();
   bdr_rsp_if rsp_chan();

   bus_decoded_byte_ram_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow copy of the byte store and window registers
   bit [7:0]              shadow_ram [BDR_RAM_BYTES];
   logic [BDR_ADDR_W-1:0] win_base = '0;
   logic [BDR_SIZE_W-1:0] win_size = BDR_RAM_SIZE_RESET;

   bus_access_type    access_queue [$];
   access_result_type result_queue [$];
   bus_access_type    cur_access;

   int unsigned send_idle_pct = 28;
   int unsigned recv_idle_pct = 67;
   int unsigned n_reads = 0, n_writes = 0, n_faults = 0;
   int unsigned n_windows = 1;
   int unsigned n_mismatch = 0;

   always #5 clock = ~clock;

   function automatic logic [BDR_ADDR_W-1:0] window_span();
      return (win_size > BDR_RAM_BYTES) ? 64'(BDR_RAM_BYTES) : 64'(win_size);
   endfunction

   function automatic access_result_type ram_access(bus_access_type acc);
      access_result_type     res;
      logic [BDR_ADDR_W-1:0] span;
      logic [BDR_ADDR_W-1:0] offset;
      span = window_span();
      offset = acc.address - win_base;
      res.read_data = '0;
      res.status = BDR_ST_OK;
      res.fault_address = '0;
      res.fault_width = '0;
      res.fault_kind = '0;
      if (acc.width != 4'd1 && acc.width != 4'd2 && acc.width != 4'd4 && acc.width != 4'd8)
         res.status = BDR_ST_BAD_WIDTH;
      else if (acc.address < win_base || offset >= span || 64'(acc.width) > span - offset)
         res.status = BDR_ST_UNMAPPED;
      if (res.status == BDR_ST_OK) begin
         for (int i = 0; i < int'(acc.width); i++) begin
            if (acc.opcode == BDR_OP_WRITE)
               shadow_ram[int'(offset) + i] = acc.wdata[8*i +: 8];
            else
               res.read_data[8*i +: 8] = shadow_ram[int'(offset) + i];
         end
      end else begin
         res.fault_address = acc.address;
         res.fault_width = acc.width;
         res.fault_kind = acc.kind;
      end
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      access_result_type predicted;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predicted = ram_access(cur_access);
            result_queue = {result_queue, predicted};
            if (predicted.status != BDR_ST_OK)
               n_faults++;
            else if (cur_access.opcode == BDR_OP_WRITE)
               n_writes++;
            else
               n_reads++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_access = access_queue.pop_front();
               req_chan.opcode       <= cur_access.opcode;
               req_chan.bus_address  <= cur_access.address;
               req_chan.access_width <= cur_access.width;
               req_chan.write_data   <= cur_access.wdata;
               req_chan.access_kind  <= cur_access.kind;
               req_chan.valid        <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      access_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (result_queue.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("%0t: response with no request outstanding, status %0d", $realtime,
                           rsp_chan.status);
            end else begin
               want = result_queue.pop_front();
               if (rsp_chan.read_data !== want.read_data || rsp_chan.status !== want.status ||
                   rsp_chan.fault_address !== want.fault_address ||
                   rsp_chan.fault_width !== want.fault_width ||
                   rsp_chan.fault_kind !== want.fault_kind) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display({"%0t: mismatch exp/act data %h/%h status %0d/%0d ",
                               "faddr %h/%h fwidth %0d/%0d fkind %0d/%0d"}, $realtime,
                              want.read_data, rsp_chan.read_data, want.status, rsp_chan.status,
                              want.fault_address, rsp_chan.fault_address,
                              want.fault_width, rsp_chan.fault_width,
                              want.fault_kind, rsp_chan.fault_kind);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_access(input logic op, input logic [BDR_ADDR_W-1:0] addr,
                               input logic [BDR_WIDTH_W-1:0] w,
                               input logic [BDR_DATA_W-1:0] data,
                               input logic [BDR_KIND_W-1:0] kind);
      bus_access_type acc;
      acc.opcode = op;
      acc.address = addr;
      acc.width = w;
      acc.wdata = data;
      acc.kind = kind;
      access_queue = {access_queue, acc};
   endtask

   task automatic wait_drained();
      while (access_queue.size() != 0 || req_chan.valid || result_queue.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_window(input logic [BDR_ADDR_W-1:0] base,
                                 input logic [BDR_SIZE_W-1:0] size);
      logic [BDR_ADDR_W-1:0] junk;
      junk = {$urandom, $urandom};
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= BDR_CSR_RAM_BASE;
      csr_write_data <= base;
      win_base = base;
      @(posedge clock);
      csr_index <= BDR_CSR_RAM_SIZE;
      csr_write_data <= {junk[BDR_ADDR_W-1:BDR_SIZE_W], size};
      win_size = size;
      @(posedge clock);
      // unused index, must be ignored
      csr_index <= n_windows[0] ? CSR_SPARE_B : CSR_SPARE_A;
      csr_write_data <= junk;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      n_windows++;
   endtask

   task automatic run_phase(input int unsigned count, input int unsigned send_pct,
                            input int unsigned recv_pct);
      logic [BDR_ADDR_W-1:0]  span;
      logic [BDR_ADDR_W-1:0]  offset;
      logic [BDR_ADDR_W-1:0]  addr;
      logic [BDR_WIDTH_W-1:0] w;
      int unsigned            pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      span = window_span();
      for (int n = 0; n < int'(count); n++) begin
         pick = $urandom_range(99);
         w = 4'd1 << $urandom_range(3);
         if ($urandom_range(99) < 12)
            w = 4'($urandom_range(15));
         if (pick < 55)
            offset = 64'($urandom_range(63));          // hot region, read-after-write
         else if (pick < 70)
            offset = span - 64'($urandom_range(1, 10)); // near the window end, may straddle it
         else if (pick < 82)
            offset = 64'($urandom) % ((span == 0) ? 64'd1 : span);
         else
            offset = -64'($urandom_range(1, 16));      // just below base
         addr = win_base + offset;
         if (pick >= 92)
            addr = {$urandom, $urandom};
         queue_access(1'($urandom_range(1)), addr, w, {$urandom, $urandom},
                      3'($urandom_range(7)));
      end
      wait_drained();
   endtask

   initial begin
      csr_write_enable = 1'b0;
      csr_index = BDR_CSR_RAM_BASE;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.opcode = BDR_OP_READ;
      req_chan.bus_address = '0;
      req_chan.access_width = '0;
      req_chan.write_data = '0;
      req_chan.access_kind = KIND_FETCH;
      rsp_chan.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset window [0, 64K)
      queue_access(BDR_OP_WRITE, 64'h0, 4'd8, 64'h0123_4567_89ab_cdef, KIND_STORE);
      queue_access(BDR_OP_READ,  64'h0, 4'd8, 64'h0, KIND_LOAD);
      queue_access(BDR_OP_READ,  64'h3, 4'd1, 64'h0, KIND_FETCH);
      queue_access(BDR_OP_READ,  64'h5, 4'd2, 64'h0, KIND_LOAD);
      queue_access(BDR_OP_READ,  64'h1, 4'd4, 64'h0, KIND_WALK);
      queue_access(BDR_OP_WRITE, 64'h7, 4'd4, 64'hffff_ffff_a5c3_e1f7, KIND_IMAGE);
      queue_access(BDR_OP_READ,  64'h4, 4'd8, 64'h0, KIND_LOAD);
      queue_access(BDR_OP_WRITE, 64'hfff8, 4'd8, '1, KIND_STORE);
      queue_access(BDR_OP_READ,  64'hfff8, 4'd8, 64'h0, KIND_LOAD);
      queue_access(BDR_OP_WRITE, 64'hffff, 4'd1, 64'h5a, KIND_STORE);
      queue_access(BDR_OP_READ,  64'hffff, 4'd1, 64'h0, KIND_LOAD);
      queue_access(BDR_OP_READ,  64'hffff, 4'd2, 64'h0, KIND_RSVD5);
      queue_access(BDR_OP_WRITE, 64'hfff9, 4'd8, 64'h0, KIND_STORE);
      queue_access(BDR_OP_READ,  64'hfff8, 4'd8, 64'h0, KIND_LOAD);
      queue_access(BDR_OP_READ,  64'h0, 4'd0, 64'h0, KIND_LOAD);
      queue_access(BDR_OP_WRITE, ADDR_TOP, 4'd3, '1, KIND_RSVD7);
      queue_access(BDR_OP_READ,  64'h10, 4'd9, 64'h0, KIND_FETCH);
      queue_access(BDR_OP_READ,  ADDR_TOP, 4'd15, 64'h0, KIND_RSVD7);
      queue_access(BDR_OP_READ,  ADDR_TOP, 4'd1, 64'h0, KIND_WALK);
      queue_access(BDR_OP_WRITE, 64'h1_0000, 4'd2, 64'h1234, KIND_STORE);
      queue_access(BDR_OP_READ,  64'h10, 4'd8, 64'h0, KIND_LOAD);
      queue_access(BDR_OP_WRITE, 64'hfffe, 4'd2, 64'hbeef, KIND_STORE);
      queue_access(BDR_OP_READ,  64'hfffe, 4'd2, 64'h0, KIND_LOAD);
      run_phase(80, 28, 67);

      program_window({$urandom, $urandom}, 17'($urandom_range(1, BDR_RAM_BYTES)));
      run_phase(80, 28, 67);
      // window runs off the top of the address space
      program_window(ADDR_TOP - 64'd31, 17'h10000);
      run_phase(80, 67, 28);
      // empty window
      program_window({$urandom, $urandom}, 17'h0);
      run_phase(40, 67, 28);
      // oversize window, clamped to the store
      program_window(64'h1000, 17'h1ffff);
      run_phase(80, 0, 0);
      program_window(ADDR_TOP, 17'h1);
      run_phase(60, 0, 0);
      program_window(64'h0, 17'h10000);
      run_phase(80, 0, 0);

      n_mismatch += result_queue.size();
      $display("Checked %0d reads, %0d writes and %0d faulting accesses over %0d windows",
               n_reads, n_writes, n_faults, n_windows);
      $display("Windows included empty, single byte, oversize and wrapping past the top");
      if (n_mismatch == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d requests queued and %0d responses outstanding",
               access_queue.size(), result_queue.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
